>>> rtl/core/kert_pkg.sv
// kert_pkg: shared types and constants of the key edge and repeat tracker
`timescale 1ns / 1ps

package kert_pkg;

  localparam int KEY_W = 8;
  localparam int RAW_W = 8;
  localparam int DELAY_W = 8;
  localparam int CNT_W = 9;
  localparam int PRESS_BIT = 7;
  localparam int KEY_COUNT_DEF = 256;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 16;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd10;

  // per-key entry held in the state memory
  typedef struct packed {
    logic             prev_pressed;
    logic [CNT_W-1:0] hold_count;
  } kert_entry_t;

  // result flags, lowest bit first in tdata: pressed, triggered, released, repeat_res
  typedef struct packed {
    logic repeat_res;
    logic released;
    logic triggered;
    logic pressed;
  } kert_flags_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } kert_state_t;

endpackage

>>> rtl/core/kert_state_mem.sv
// kert_state_mem: per-key state memory, one write and one registered read port
`timescale 1ns / 1ps

module kert_state_mem #(
  parameter int DEPTH = 256,
  parameter int AW = 8
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output kert_pkg::kert_entry_t rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  kert_pkg::kert_entry_t wr_data
);
  import kert_pkg::*;

  kert_entry_t mem [DEPTH];
  kert_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/kert_update.sv
// kert_update: edge detect and hold counter update for one key sample
`timescale 1ns / 1ps

module kert_update (
  input  kert_pkg::kert_entry_t               cur,
  input  logic [kert_pkg::RAW_W-1:0]          raw_state,
  input  logic [kert_pkg::DELAY_W-1:0]        repeat_delay,
  input  logic                                in_range,
  output kert_pkg::kert_entry_t               nxt,
  output kert_pkg::kert_flags_t               flags
);
  import kert_pkg::*;

  logic             now;
  logic             held;
  logic [CNT_W-1:0] delay_ext;
  logic [CNT_W-1:0] cnt_upd;
  logic             rep;

  assign now       = raw_state[PRESS_BIT];
  assign held      = (raw_state != '0);
  assign delay_ext = CNT_W'(repeat_delay);

  always_comb begin
    cnt_upd = '0;
    rep     = 1'b0;
    if (held) begin
      // saturate one past the delay
      cnt_upd = (cur.hold_count <= delay_ext) ? cur.hold_count + CNT_W'(1) : cur.hold_count;
      rep     = (cnt_upd == CNT_W'(1)) || (cnt_upd > delay_ext);
    end
  end

  assign nxt.prev_pressed = now;
  assign nxt.hold_count   = cnt_upd;

  assign flags.pressed    = in_range & now;
  assign flags.triggered  = in_range & now & ~cur.prev_pressed;
  assign flags.released   = in_range & ~now & cur.prev_pressed;
  assign flags.repeat_res = in_range & rep;

endmodule

>>> rtl/core/key_edge_and_repeat_tracker.sv
// key_edge_and_repeat_tracker: per-key edge detect and typematic repeat over a state memory
`timescale 1ns / 1ps
// path: an accepted item is held in the lookup stage register, then in the output register
// throughput: one item per cycle unless out_tready stalls, set by the single read-modify-write
//   of the state memory; a back-to-back same-key hit is served from a write-forward register
// reset: rst_n synchronous active low; afterwards a clearing pass zeroes every address of
//   the state memory, in_tready stays low meanwhile, cfg writes are taken at any time

module key_edge_and_repeat_tracker #(
  parameter int KEY_COUNT = kert_pkg::KEY_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration: repeat_delay
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kert_pkg::DELAY_W-1:0]         cfg_data,
  // input items
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [kert_pkg::IN_TDATA_W-1:0]      in_tdata,   // [7:0] key_index, [15:8] raw_state
  // result items
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [7:0] key_id, [8] pressed, [9] triggered, [10] released, [11] repeat_res, [15:12] zero
  output logic [kert_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import kert_pkg::*;

  localparam int AW    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  // wide enough for the key and for KEY_COUNT itself
  localparam int IDX_W = ((AW > KEY_W) ? AW : KEY_W) + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(KEY_COUNT - 1);

  // sweep state
  kert_state_t st_r, st_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          clr_we;
  logic          run_en;

  // config
  logic [DELAY_W-1:0] delay_r;

  // input decode
  logic [KEY_W-1:0] in_key;
  logic [RAW_W-1:0] in_raw;
  logic [IDX_W-1:0] in_key_ext;
  logic             in_accept;

  // lookup stage
  logic             s1_v_r;
  logic [KEY_W-1:0] s1_key_r;
  logic [RAW_W-1:0] s1_raw_r;
  logic             s1_in_range_r;
  logic [AW-1:0]    s1_addr_r;
  logic             s1_adv;

  // write-forward register: last entry written to the memory
  logic             fwd_v_r;
  logic [AW-1:0]    fwd_addr_r;
  kert_entry_t      fwd_data_r;

  // memory ports
  kert_entry_t      rd_data;
  kert_entry_t      cur;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  kert_entry_t      wr_data;

  kert_entry_t      upd_nxt;
  kert_flags_t      upd_flags;

  // output register
  logic             out_v_r;
  logic [KEY_W-1:0] out_key_r;
  kert_flags_t      out_flags_r;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      delay_r <= cfg_data;
    end
  end

  // ---------------- clearing sweep ----------------
  always_comb begin
    st_nxt       = st_r;
    clr_addr_nxt = clr_addr_r;
    case (st_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        st_nxt = ST_RUN;
      end
      default: begin
        st_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    clr_we = 1'b0;
    run_en = 1'b0;
    case (st_r)
      ST_CLEAR: clr_we = 1'b1;
      ST_RUN:   run_en = 1'b1;
      default: begin
        clr_we = 1'b0;
        run_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      st_r       <= st_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // ---------------- input side ----------------
  assign in_key     = in_tdata[KEY_W-1:0];
  assign in_raw     = in_tdata[KEY_W+RAW_W-1:KEY_W];
  assign in_key_ext = IDX_W'(in_key);

  // stage 1 moves on whenever the output register is free or being drained
  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = run_en && (!s1_v_r || s1_adv);
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_key_r      <= in_key;
      s1_raw_r      <= in_raw;
      s1_in_range_r <= (in_key_ext < IDX_W'(KEY_COUNT));
      s1_addr_r     <= in_key_ext[AW-1:0];
    end
  end

  // ---------------- state memory ----------------
  kert_state_mem #(
    .DEPTH (KEY_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (in_key_ext[AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // the read was taken at or before the last write; the forward register covers a same-key hit
  assign cur = (fwd_v_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : rd_data;

  kert_update u_upd (
    .cur          (cur),
    .raw_state    (s1_raw_r),
    .repeat_delay (delay_r),
    .in_range     (s1_in_range_r),
    .nxt          (upd_nxt),
    .flags        (upd_flags)
  );

  // out-of-range keys leave the state untouched
  assign wr_en   = clr_we || (s1_adv && s1_in_range_r);
  assign wr_addr = clr_we ? clr_addr_r : s1_addr_r;
  assign wr_data = clr_we ? kert_entry_t'('0) : upd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else if (wr_en) begin
      fwd_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr_r <= wr_addr;
      fwd_data_r <= wr_data;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_key_r   <= s1_key_r;
      out_flags_r <= upd_flags;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_TDATA_W - KEY_W - 4){1'b0}}, out_flags_r, out_key_r};

  // ---------------- assertions ----------------
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CLEAR) |-> !in_tready)
    else $error("item accepted during clearing pass");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_v_r)
    else $error("accepted item lost before lookup stage");

  a_item_write_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !clr_we) |-> (s1_v_r && s1_in_range_r))
    else $error("state write without a valid in-range item");

  a_trigger_implies_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[KEY_W+1]) |-> out_tdata[KEY_W])
    else $error("triggered without pressed");

  a_no_edge_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[KEY_W+1] && out_tdata[KEY_W+2]))
    else $error("triggered and released together");

endmodule
